@@ hdl/cdte_pkg.sv @@
// Shared types, constants and the month-name decoder for the civil-date-to-epoch pipeline.
`timescale 1ns / 1ps

package cdte_pkg;

   localparam int YEAR_W   = 14;
   localparam int NAME_W   = 24;
   localparam int DAY_W    = 6;
   localparam int HOUR_W   = 5;
   localparam int MIN_W    = 6;
   localparam int SEC_W    = 6;
   localparam int EPOCH_W  = 38;
   localparam int STATUS_W = 2;
   localparam int TOD_W    = 17;
   localparam int DOY_W    = 9;
   localparam int ERA_W    = 5;
   localparam int YOE_W    = 9;
   localparam int DOE_W    = 18;
   localparam int DAYS_W   = 22;
   localparam int MONTHS   = 12;
   localparam int MON_IDX_W = 4;

   localparam logic [YEAR_W-1:0] YEAR_MIN     = 14'd1970;
   localparam logic [YEAR_W-1:0] YEAR_MAX     = 14'd9999;
   localparam logic [DAY_W-1:0]  DAY_MIN      = 6'd1;
   localparam logic [DAY_W-1:0]  DAY_MAX      = 6'd31;
   localparam logic [HOUR_W-1:0] HOUR_MAX     = 5'd23;
   localparam logic [MIN_W-1:0]  MINUTE_MAX   = 6'd59;
   localparam logic [SEC_W-1:0]  SECOND_MAX   = 6'd60;

   localparam logic [11:0]       SECS_PER_HOUR   = 12'd3600;
   localparam logic [5:0]        SECS_PER_MINUTE = 6'd60;
   localparam logic [16:0]       SECS_PER_DAY    = 17'd86400;
   localparam logic [8:0]        YEARS_PER_ERA   = 9'd400;
   localparam logic [8:0]        DAYS_PER_YEAR   = 9'd365;
   localparam logic [17:0]       DAYS_PER_ERA    = 18'd146097;
   localparam logic [19:0]       EPOCH_SHIFT     = 20'd719468;
   // floor(x / 25) == (x * 41) >> 10 for every x below 625.
   localparam logic [5:0]        ERA_RECIP       = 6'd41;
   localparam logic [EPOCH_W-1:0] EPOCH_MAX      = 38'd253402300800;

   // Months before March belong to the previous March-based year.
   localparam logic [MON_IDX_W-1:0] MARCH_INDEX = 4'd2;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_MONTH = 2'd1,
      STATUS_RANGE     = 2'd2
   } status_type;

   localparam logic [NAME_W-1:0] MONTH_NAMES [MONTHS] = '{
      "Jan", "Feb", "Mar", "Apr", "May", "Jun",
      "Jul", "Aug", "Sep", "Oct", "Nov", "Dec"
   };

   // First day of each month counted from March 1, i.e. (153 * mp + 2) / 5.
   localparam logic [DOY_W-1:0] DOY_BASE [MONTHS] = '{
      9'd306, 9'd337, 9'd0,   9'd31,  9'd61,  9'd92,
      9'd122, 9'd153, 9'd184, 9'd214, 9'd245, 9'd275
   };

   typedef struct packed {
      logic                 known;
      logic [MON_IDX_W-1:0] idx;
   } month_type;

   typedef struct packed {
      status_type        status;
      logic [YEAR_W-1:0] year_adj;
      logic [DOY_W-1:0]  doy;
      logic [TOD_W-1:0]  tod;
   } parse_type;

   typedef struct packed {
      status_type        status;
      logic [DAYS_W-1:0] days;
      logic [TOD_W-1:0]  tod;
   } days_type;

   function automatic month_type decode_month(input logic [NAME_W-1:0] name);
      month_type res;
      res.known = 1'b0;
      res.idx   = '0;
      for (int i = 0; i < MONTHS; i++) begin
         if (name == MONTH_NAMES[i]) begin
            res.known = 1'b1;
            res.idx   = MON_IDX_W'(i);
         end
      end
      return res;
   endfunction

endpackage

@@ hdl/civil_date_to_epoch_seconds_top.sv @@
// Top level of the UTC civil-date to Unix epoch seconds converter.
`timescale 1ns / 1ps

// This block converts one UTC date and time per transfer into seconds since
// 1970-01-01 00:00:00. The month arrives as a three-letter English name in
// ASCII ("Jan" to "Dec", case-sensitive, first letter in the top byte). An
// unknown name gives status 1 and zero seconds; a year outside 1970 to 9999,
// a day outside 1 to 31, an hour above 23, a minute above 59 or a second
// above 60 gives status 2 and zero seconds. Month lengths are not checked,
// so Feb 31 rolls into March, and a second of 60 counts as one more second.
// The block is a seven-stage pipeline with a valid bit in every stage: it
// takes one transfer per clock cycle while the result side is not stalled.
// Stage one decodes and checks the fields, stages two to five compute days
// since the epoch with the 400-year era method, stage six multiplies by 86400
// and stage seven adds the time of day. A stall on the result side backs up
// stage by stage, so empty stages keep filling while the output waits;
// results leave in input order.

module civil_date_to_epoch_seconds_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [cdte_pkg::YEAR_W-1:0]    req_year,
   input  logic [cdte_pkg::NAME_W-1:0]    req_month_name,
   input  logic [cdte_pkg::DAY_W-1:0]     req_day_of_month,
   input  logic [cdte_pkg::HOUR_W-1:0]    req_hour_of_day,
   input  logic [cdte_pkg::MIN_W-1:0]     req_minute_of_hour,
   input  logic [cdte_pkg::SEC_W-1:0]     req_second_of_minute,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [cdte_pkg::EPOCH_W-1:0]   rsp_epoch_seconds,
   output logic [cdte_pkg::STATUS_W-1:0]  rsp_status
);

   logic                  parse_valid, parse_ready;
   cdte_pkg::parse_type   parse_data;
   logic                  days_valid, days_ready;
   cdte_pkg::days_type    days_data;
   cdte_pkg::status_type  status;

   // Field decode and range checks.
   cdte_parse u_parse (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (req_valid),
      .in_ready         (req_ready),
      .year             (req_year),
      .month_name       (req_month_name),
      .day_of_month     (req_day_of_month),
      .hour_of_day      (req_hour_of_day),
      .minute_of_hour   (req_minute_of_hour),
      .second_of_minute (req_second_of_minute),
      .out_valid        (parse_valid),
      .out_ready        (parse_ready),
      .out_data         (parse_data)
   );

   // Era split and day count.
   cdte_days u_days (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (parse_valid),
      .in_ready  (parse_ready),
      .in_data   (parse_data),
      .out_valid (days_valid),
      .out_ready (days_ready),
      .out_data  (days_data)
   );

   // Scaling to seconds and output register.
   cdte_scale u_scale (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (days_valid),
      .in_ready      (days_ready),
      .in_data       (days_data),
      .out_valid     (rsp_valid),
      .out_ready     (rsp_ready),
      .epoch_seconds (rsp_epoch_seconds),
      .status        (status)
   );

   assign rsp_status = status;

`ifndef ASSERT_OFF
   // An error result never carries a nonzero time.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status != cdte_pkg::STATUS_OK) |-> rsp_epoch_seconds == '0)
      else $error("error result with nonzero epoch seconds");

   // A valid conversion never exceeds the end of year 9999.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status == cdte_pkg::STATUS_OK) |->
         rsp_epoch_seconds <= cdte_pkg::EPOCH_MAX)
      else $error("epoch seconds beyond the last valid date");

   // Back pressure only starts at the output, so a blocked input means a waiting result.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input blocked while the output is free");
`endif

endmodule

@@ hdl/cdte_parse.sv @@
// First pipeline stage: month decode, range checks, March-based year and day, time of day.
`timescale 1ns / 1ps

module cdte_parse (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [cdte_pkg::YEAR_W-1:0]   year,
   input  logic [cdte_pkg::NAME_W-1:0]   month_name,
   input  logic [cdte_pkg::DAY_W-1:0]    day_of_month,
   input  logic [cdte_pkg::HOUR_W-1:0]   hour_of_day,
   input  logic [cdte_pkg::MIN_W-1:0]    minute_of_hour,
   input  logic [cdte_pkg::SEC_W-1:0]    second_of_minute,
   output logic                          out_valid,
   input  logic                          out_ready,
   output cdte_pkg::parse_type           out_data
);

   logic                 valid_ff, valid_in;
   cdte_pkg::parse_type  data_ff, data_in;
   cdte_pkg::month_type  month;
   logic                 out_of_range;

   always_comb begin
      month = cdte_pkg::decode_month(month_name);
      out_of_range = (year < cdte_pkg::YEAR_MIN) || (year > cdte_pkg::YEAR_MAX) ||
                     (day_of_month < cdte_pkg::DAY_MIN) ||
                     (day_of_month > cdte_pkg::DAY_MAX) ||
                     (hour_of_day > cdte_pkg::HOUR_MAX) ||
                     (minute_of_hour > cdte_pkg::MINUTE_MAX) ||
                     (second_of_minute > cdte_pkg::SECOND_MAX);

      if (!month.known) begin
         data_in.status = cdte_pkg::STATUS_BAD_MONTH;
      end else if (out_of_range) begin
         data_in.status = cdte_pkg::STATUS_RANGE;
      end else begin
         data_in.status = cdte_pkg::STATUS_OK;
      end

      // January and February count toward the previous year.
      data_in.year_adj = year - cdte_pkg::YEAR_W'(month.idx < cdte_pkg::MARCH_INDEX);
      data_in.doy = cdte_pkg::DOY_BASE[month.idx] + cdte_pkg::DOY_W'(day_of_month) -
                    cdte_pkg::DOY_W'(1);
      data_in.tod = cdte_pkg::TOD_W'(hour_of_day) * cdte_pkg::TOD_W'(cdte_pkg::SECS_PER_HOUR) +
                    cdte_pkg::TOD_W'(minute_of_hour) *
                    cdte_pkg::TOD_W'(cdte_pkg::SECS_PER_MINUTE) +
                    cdte_pkg::TOD_W'(second_of_minute);
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

@@ hdl/cdte_days.sv @@
// Four pipeline stages that turn the March-based year and day into days since the epoch.
`timescale 1ns / 1ps

module cdte_days (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  cdte_pkg::parse_type  in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output cdte_pkg::days_type   out_data
);

   typedef struct packed {
      cdte_pkg::status_type        status;
      logic [cdte_pkg::ERA_W-1:0]  era;
      logic [cdte_pkg::YEAR_W-1:0] year_adj;
      logic [cdte_pkg::DOY_W-1:0]  doy;
      logic [cdte_pkg::TOD_W-1:0]  tod;
   } era_stage_type;

   typedef struct packed {
      cdte_pkg::status_type        status;
      logic [cdte_pkg::ERA_W-1:0]  era;
      logic [cdte_pkg::YOE_W-1:0]  yoe;
      logic [cdte_pkg::DOY_W-1:0]  doy;
      logic [cdte_pkg::TOD_W-1:0]  tod;
   } yoe_stage_type;

   typedef struct packed {
      cdte_pkg::status_type        status;
      logic [cdte_pkg::ERA_W-1:0]  era;
      logic [cdte_pkg::DOE_W-1:0]  doe;
      logic [cdte_pkg::TOD_W-1:0]  tod;
   } doe_stage_type;

   era_stage_type       s2_ff, s2_in;
   yoe_stage_type       s3_ff, s3_in;
   doe_stage_type       s4_ff, s4_in;
   cdte_pkg::days_type  s5_ff, s5_in;
   logic                s2_v_ff, s2_v_in, s2_rdy;
   logic                s3_v_ff, s3_v_in, s3_rdy;
   logic                s4_v_ff, s4_v_in, s4_rdy;
   logic                s5_v_ff, s5_v_in, s5_rdy;
   logic [15:0]         era_prod;
   logic [cdte_pkg::YEAR_W-1:0] yoe_full;
   logic [1:0]          centuries;
   logic [22:0]         days_full;

   always_comb begin
      // year / 400 computed as (year >> 4) / 25.
      era_prod = 16'(in_data.year_adj[cdte_pkg::YEAR_W-1:4]) * 16'(cdte_pkg::ERA_RECIP);
      s2_in.status   = in_data.status;
      s2_in.era      = era_prod[14:10];
      s2_in.year_adj = in_data.year_adj;
      s2_in.doy      = in_data.doy;
      s2_in.tod      = in_data.tod;

      yoe_full = s2_ff.year_adj -
                 cdte_pkg::YEAR_W'(s2_ff.era) * cdte_pkg::YEAR_W'(cdte_pkg::YEARS_PER_ERA);
      s3_in.status = s2_ff.status;
      s3_in.era    = s2_ff.era;
      s3_in.yoe    = yoe_full[cdte_pkg::YOE_W-1:0];
      s3_in.doy    = s2_ff.doy;
      s3_in.tod    = s2_ff.tod;

      if (s3_ff.yoe >= 9'd300) begin
         centuries = 2'd3;
      end else if (s3_ff.yoe >= 9'd200) begin
         centuries = 2'd2;
      end else if (s3_ff.yoe >= 9'd100) begin
         centuries = 2'd1;
      end else begin
         centuries = 2'd0;
      end
      s4_in.status = s3_ff.status;
      s4_in.era    = s3_ff.era;
      s4_in.doe    = cdte_pkg::DOE_W'(s3_ff.yoe) * cdte_pkg::DOE_W'(cdte_pkg::DAYS_PER_YEAR) +
                     cdte_pkg::DOE_W'(s3_ff.yoe[cdte_pkg::YOE_W-1:2]) -
                     cdte_pkg::DOE_W'(centuries) + cdte_pkg::DOE_W'(s3_ff.doy);
      s4_in.tod    = s3_ff.tod;

      days_full = 23'(s4_ff.era) * 23'(cdte_pkg::DAYS_PER_ERA) + 23'(s4_ff.doe) -
                  23'(cdte_pkg::EPOCH_SHIFT);
      s5_in.status = s4_ff.status;
      s5_in.days   = days_full[cdte_pkg::DAYS_W-1:0];
      s5_in.tod    = s4_ff.tod;
   end

   assign s5_rdy   = !s5_v_ff || out_ready;
   assign s4_rdy   = !s4_v_ff || s5_rdy;
   assign s3_rdy   = !s3_v_ff || s4_rdy;
   assign s2_rdy   = !s2_v_ff || s3_rdy;
   assign in_ready = s2_rdy;

   assign s2_v_in = s2_rdy ? in_valid : s2_v_ff;
   assign s3_v_in = s3_rdy ? s2_v_ff  : s3_v_ff;
   assign s4_v_in = s4_rdy ? s3_v_ff  : s4_v_ff;
   assign s5_v_in = s5_rdy ? s4_v_ff  : s5_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
      end else begin
         s2_v_ff <= s2_v_in;
         s3_v_ff <= s3_v_in;
         s4_v_ff <= s4_v_in;
         s5_v_ff <= s5_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_rdy) begin
         s2_ff <= s2_in;
      end
      if (s3_rdy) begin
         s3_ff <= s3_in;
      end
      if (s4_rdy) begin
         s4_ff <= s4_in;
      end
      if (s5_rdy) begin
         s5_ff <= s5_in;
      end
   end

   assign out_valid = s5_v_ff;
   assign out_data  = s5_ff;

endmodule

@@ hdl/cdte_scale.sv @@
// Two pipeline stages: days times seconds per day, then time of day added and errors zeroed.
`timescale 1ns / 1ps

module cdte_scale (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  cdte_pkg::days_type             in_data,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic [cdte_pkg::EPOCH_W-1:0]   epoch_seconds,
   output cdte_pkg::status_type           status
);

   typedef struct packed {
      cdte_pkg::status_type         status;
      logic [cdte_pkg::EPOCH_W-1:0] prod;
      logic [cdte_pkg::TOD_W-1:0]   tod;
   } prod_stage_type;

   typedef struct packed {
      cdte_pkg::status_type         status;
      logic [cdte_pkg::EPOCH_W-1:0] secs;
   } out_stage_type;

   prod_stage_type  s6_ff, s6_in;
   out_stage_type   s7_ff, s7_in;
   logic            s6_v_ff, s6_v_in, s6_rdy;
   logic            s7_v_ff, s7_v_in, s7_rdy;
   logic [38:0]     prod_full;
   logic [cdte_pkg::EPOCH_W-1:0] sum;

   always_comb begin
      prod_full = 39'(in_data.days) * 39'(cdte_pkg::SECS_PER_DAY);
      s6_in.status = in_data.status;
      s6_in.prod   = prod_full[cdte_pkg::EPOCH_W-1:0];
      s6_in.tod    = in_data.tod;

      sum = s6_ff.prod + cdte_pkg::EPOCH_W'(s6_ff.tod);
      s7_in.status = s6_ff.status;
      s7_in.secs   = (s6_ff.status == cdte_pkg::STATUS_OK) ? sum : '0;
   end

   assign s7_rdy   = !s7_v_ff || out_ready;
   assign s6_rdy   = !s6_v_ff || s7_rdy;
   assign in_ready = s6_rdy;

   assign s6_v_in = s6_rdy ? in_valid : s6_v_ff;
   assign s7_v_in = s7_rdy ? s6_v_ff  : s7_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_v_ff <= 1'b0;
         s7_v_ff <= 1'b0;
      end else begin
         s6_v_ff <= s6_v_in;
         s7_v_ff <= s7_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s6_rdy) begin
         s6_ff <= s6_in;
      end
      if (s7_rdy) begin
         s7_ff <= s7_in;
      end
   end

   assign out_valid     = s7_v_ff;
   assign epoch_seconds = s7_ff.secs;
   assign status        = s7_ff.status;

endmodule

@@ verif/civil_date_to_epoch_seconds_top_test.sv @@
// Self-checking testbench for the civil-date to Unix epoch seconds converter.
`timescale 1ns / 1ps

// Every date sent to the block is run through a predictor in this file that
// decodes the month name, range-checks the fields and counts days with the
// March-based 400-year era method. The predicted seconds and status go into a
// queue when the input transfer happens. Each result transfer is compared
// field by field with the oldest entry of that queue.
//
// The stimulus starts with a few directed dates: every month name, both ends
// of the valid date span (including a leap second on the very last second),
// a February day that rolls over into March, each field just outside its
// valid span, and unknown month names with bad fields as well. Then comes a
// long random part. Most of it is well-formed dates with random content. The
// rest is dates with one field out of range or all fields scrambled, and
// unknown month names. Both sides insert random idle bursts, switched on and
// off in segments, and no new burst starts in the tail of the run.

module civil_date_to_epoch_seconds_top_test;

   localparam int          RANDOM_ITEMS    = 1330;
   localparam int          QUIET_TAIL      = 200;
   localparam int          DRAIN_CYCLES    = 20;
   localparam int          MAX_REPORTS     = 10;
   localparam int unsigned FIRST_YEAR      = 1970;
   localparam int unsigned LAST_YEAR       = 9999;
   localparam int unsigned LAST_DAY        = 31;
   localparam int unsigned LAST_HOUR       = 23;
   localparam int unsigned LAST_MINUTE     = 59;
   localparam int unsigned LEAP_SECOND     = 60;
   localparam longint unsigned ERA_DAYS    = 146097;
   localparam longint unsigned ERA_YEARS   = 400;
   localparam longint unsigned EPOCH_DAYS  = 719468;
   localparam longint unsigned DAY_SECONDS = 86400;
   localparam longint unsigned HOUR_SECONDS = 3600;

   localparam logic [cdte_pkg::NAME_W-1:0] MONTH_ABBREV [12] = '{
      "Jan", "Feb", "Mar", "Apr", "May", "Jun",
      "Jul", "Aug", "Sep", "Oct", "Nov", "Dec"
   };

   typedef struct {
      logic [cdte_pkg::YEAR_W-1:0] year;
      logic [cdte_pkg::NAME_W-1:0] name;
      logic [cdte_pkg::DAY_W-1:0]  day;
      logic [cdte_pkg::HOUR_W-1:0] hour;
      logic [cdte_pkg::MIN_W-1:0]  minute;
      logic [cdte_pkg::SEC_W-1:0]  second;
   } civil_date_type;

   typedef struct {
      logic [cdte_pkg::EPOCH_W-1:0] seconds;
      cdte_pkg::status_type         status;
   } epoch_reading_type;

   // All inputs of the block hold known values from time zero on.
   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [cdte_pkg::YEAR_W-1:0]   req_year = '0;
   logic [cdte_pkg::NAME_W-1:0]   req_month_name = '0;
   logic [cdte_pkg::DAY_W-1:0]    req_day_of_month = '0;
   logic [cdte_pkg::HOUR_W-1:0]   req_hour_of_day = '0;
   logic [cdte_pkg::MIN_W-1:0]    req_minute_of_hour = '0;
   logic [cdte_pkg::SEC_W-1:0]    req_second_of_minute = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [cdte_pkg::EPOCH_W-1:0]  rsp_epoch_seconds;
   logic [cdte_pkg::STATUS_W-1:0] rsp_status;

   epoch_reading_type pending_epochs [$];
   int                fail_count = 0;
   int                stall_left = 0;
   bit                bursts_on = 1'b1;

   civil_date_to_epoch_seconds_top i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_year             (req_year),
      .req_month_name       (req_month_name),
      .req_day_of_month     (req_day_of_month),
      .req_hour_of_day      (req_hour_of_day),
      .req_minute_of_hour   (req_minute_of_hour),
      .req_second_of_minute (req_second_of_minute),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_epoch_seconds    (rsp_epoch_seconds),
      .rsp_status           (rsp_status)
   );

   always #5 clock = ~clock;

   // Expected seconds and status for one date. The month check comes first,
   // so an unknown name wins over any out-of-range field. The year is counted
   // from March, which puts January and February at the end of the previous
   // year and lets an oversized February day run on into March.
   function automatic epoch_reading_type predict_epoch(input civil_date_type d);
      epoch_reading_type r;
      int unsigned       mon;
      longint unsigned   y, era, yoe, mar_month, doy, doe, days;
      r.seconds = '0;
      r.status  = cdte_pkg::STATUS_OK;
      mon = 0;
      for (int i = 0; i < 12; i++) begin
         if (d.name == MONTH_ABBREV[i]) begin
            mon = i + 1;
         end
      end
      if (mon == 0) begin
         r.status = cdte_pkg::STATUS_BAD_MONTH;
      end else if (d.year < FIRST_YEAR || d.year > LAST_YEAR || d.day < 1 ||
                   d.day > LAST_DAY || d.hour > LAST_HOUR ||
                   d.minute > LAST_MINUTE || d.second > LEAP_SECOND) begin
         r.status = cdte_pkg::STATUS_RANGE;
      end else begin
         y = d.year;
         if (mon <= 2) begin
            y = y - 1;
            mar_month = mon + 9;
         end else begin
            mar_month = mon - 3;
         end
         era  = y / ERA_YEARS;
         yoe  = y - era * ERA_YEARS;
         doy  = (153 * mar_month + 2) / 5 + longint'(d.day) - 1;
         doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
         days = era * ERA_DAYS + doe - EPOCH_DAYS;
         r.seconds = cdte_pkg::EPOCH_W'(days * DAY_SECONDS +
                                        longint'(d.hour) * HOUR_SECONDS +
                                        longint'(d.minute) * 60 + longint'(d.second));
      end
      return r;
   endfunction

   function automatic civil_date_type make_date(input int unsigned year, input int month_idx,
                                                 input int unsigned day,
                                                 input int unsigned hour,
                                                 input int unsigned minute,
                                                 input int unsigned second);
      civil_date_type d;
      d.year   = cdte_pkg::YEAR_W'(year);
      d.name   = MONTH_ABBREV[month_idx];
      d.day    = cdte_pkg::DAY_W'(day);
      d.hour   = cdte_pkg::HOUR_W'(hour);
      d.minute = cdte_pkg::MIN_W'(minute);
      d.second = cdte_pkg::SEC_W'(second);
      return d;
   endfunction

   // A well-formed date, weighted toward the span ends, century years and
   // the last days of a month, where the leap-year rules and rollover bite.
   function automatic civil_date_type random_good_date();
      int unsigned year, day, second;
      case ($urandom_range(0, 9))
         0:       year = FIRST_YEAR;
         1:       year = LAST_YEAR;
         2:       year = $urandom_range(1999, 2001);
         3:       year = 100 * $urandom_range(20, 99);
         default: year = $urandom_range(FIRST_YEAR, LAST_YEAR);
      endcase
      day    = ($urandom_range(0, 3) == 0) ? $urandom_range(28, 31) : $urandom_range(1, 31);
      second = ($urandom_range(0, 9) == 0) ? LEAP_SECOND : $urandom_range(0, 59);
      return make_date(year, $urandom_range(0, 11), day, $urandom_range(0, LAST_HOUR),
                       $urandom_range(0, LAST_MINUTE), second);
   endfunction

   function automatic civil_date_type random_date();
      civil_date_type d;
      int unsigned    pick;
      pick = $urandom_range(0, 99);
      d = random_good_date();
      if (pick >= 70 && pick < 85) begin
         // Known month, one field pushed out of its span, or all fields scrambled.
         case ($urandom_range(0, 5))
            0: d.year   = ($urandom_range(0, 1) == 0)
                          ? cdte_pkg::YEAR_W'($urandom_range(0, 1969))
                          : cdte_pkg::YEAR_W'($urandom_range(10000, 16383));
            1: d.day    = ($urandom_range(0, 1) == 0) ? '0
                                                      : cdte_pkg::DAY_W'($urandom_range(32, 63));
            2: d.hour   = cdte_pkg::HOUR_W'($urandom_range(24, 31));
            3: d.minute = cdte_pkg::MIN_W'($urandom_range(60, 63));
            4: d.second = cdte_pkg::SEC_W'($urandom_range(61, 63));
            default: begin
               d.year   = cdte_pkg::YEAR_W'($urandom);
               d.day    = cdte_pkg::DAY_W'($urandom);
               d.hour   = cdte_pkg::HOUR_W'($urandom);
               d.minute = cdte_pkg::MIN_W'($urandom);
               d.second = cdte_pkg::SEC_W'($urandom);
            end
         endcase
      end else if (pick >= 85) begin
         // Mostly unknown names: pure noise, a case change or a single flipped bit.
         case ($urandom_range(0, 2))
            0:       d.name = cdte_pkg::NAME_W'($urandom);
            1:       d.name = d.name ^ (cdte_pkg::NAME_W'(8'h20) << (8 * $urandom_range(0, 2)));
            default: d.name = d.name ^ (cdte_pkg::NAME_W'(1) <<
                                        $urandom_range(0, cdte_pkg::NAME_W - 1));
         endcase
         if ($urandom_range(0, 1) == 0) begin
            d.year   = cdte_pkg::YEAR_W'($urandom);
            d.day    = cdte_pkg::DAY_W'($urandom);
            d.hour   = cdte_pkg::HOUR_W'($urandom);
            d.minute = cdte_pkg::MIN_W'($urandom);
            d.second = cdte_pkg::SEC_W'($urandom);
         end
      end
      return d;
   endfunction

   // Sends one date and records its expected result once the transfer
   // happens. Valid stays high from one date to the next unless an idle
   // burst is drawn.
   task automatic send_date(input civil_date_type d);
      int unsigned gap;
      gap = 0;
      if (bursts_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 19);
      end
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid            <= 1'b1;
      req_year             <= d.year;
      req_month_name       <= d.name;
      req_day_of_month     <= d.day;
      req_hour_of_day      <= d.hour;
      req_minute_of_hour   <= d.minute;
      req_second_of_minute <= d.second;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_epochs.push_back(predict_epoch(d));
   endtask

   // Each month name once. January carries the epoch itself, December the
   // last valid second of 9999 plus a leap second, and February the 31st of
   // a leap year, which must land on March 2.
   task automatic test_month_names();
      for (int m = 0; m < 12; m++) begin
         if (m == 0) begin
            send_date(make_date(FIRST_YEAR, m, 1, 0, 0, 0));
         end else if (m == 11) begin
            send_date(make_date(LAST_YEAR, m, LAST_DAY, LAST_HOUR, LAST_MINUTE, LEAP_SECOND));
         end else if (m == 1) begin
            send_date(make_date(2000, m, 31, 12, 0, 0));
         end else begin
            send_date(random_good_date());
         end
      end
   endtask

   // Each field one step outside its span, then every field at its maximum.
   task automatic test_field_limits();
      civil_date_type d;
      for (int k = 0; k < 8; k++) begin
         d = make_date(2024, 5, 15, 12, 30, 30);
         case (k)
            0: d.year   = cdte_pkg::YEAR_W'(FIRST_YEAR - 1);
            1: d.year   = cdte_pkg::YEAR_W'(LAST_YEAR + 1);
            2: d.day    = '0;
            3: d.day    = cdte_pkg::DAY_W'(LAST_DAY + 1);
            4: d.hour   = cdte_pkg::HOUR_W'(LAST_HOUR + 1);
            5: d.minute = cdte_pkg::MIN_W'(LAST_MINUTE + 1);
            6: d.second = cdte_pkg::SEC_W'(LEAP_SECOND + 1);
            default: begin
               d.year   = '1;
               d.day    = '1;
               d.hour   = '1;
               d.minute = '1;
               d.second = '1;
            end
         endcase
         send_date(d);
      end
   endtask

   // Unknown names must win over bad fields.
   task automatic test_unknown_month();
      civil_date_type d;
      d = make_date(0, 0, 0, 31, 63, 63);
      d.name = "jan";
      send_date(d);
      d = make_date(16383, 0, 63, 31, 63, 63);
      d.name = '1;
      send_date(d);
      d = make_date(2024, 0, 10, 10, 10, 10);
      d.name = "JAN";
      send_date(d);
   endtask

   // Idling is redrawn in segments so that quiet stretches occur, and the
   // tail of the run starts no new idle bursts on either side.
   task automatic test_random_dates();
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 150 == 0) begin
            bursts_on = ($urandom_range(0, 3) != 0);
         end
         if (n >= RANDOM_ITEMS - QUIET_TAIL) begin
            bursts_on = 1'b0;
         end
         send_date(random_date());
      end
   endtask

   // Result-side stalls come in bursts, started at random while bursts are on.
   always @(negedge clock) begin
      logic ready_next;
      ready_next = 1'b1;
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         ready_next = 1'b0;
      end else if (bursts_on && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 19) - 1;
         ready_next = 1'b0;
      end
      rsp_ready <= ready_next;
   end

   task automatic note_failure(input string what, input longint unsigned want,
                               input longint unsigned got);
      fail_count = fail_count + 1;
      if (fail_count <= MAX_REPORTS) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $realtime, what, want, got);
      end
   endtask

   // Each result transfer is checked against the oldest expected result.
   always @(posedge clock) begin
      epoch_reading_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_epochs.size() == 0) begin
            note_failure("unexpected result", 0, rsp_epoch_seconds);
         end else begin
            want = pending_epochs.pop_front();
            if (rsp_epoch_seconds !== want.seconds) begin
               note_failure("epoch_seconds", want.seconds, rsp_epoch_seconds);
            end
            if (rsp_status !== want.status) begin
               note_failure("status", want.status, rsp_status);
            end
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_month_names();
      test_field_limits();
      test_unknown_month();
      test_random_dates();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_epochs.size() != 0) @(posedge clock);
      // Keep waiting so that any stray result still shows up.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_epochs.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // The slowest correct run is well under this.
   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
